// ===== rtl/mwuj_pkg.sv =====
// shared types, operation codes and defaults for the undo-journal word memory
package mwuj_pkg;

  localparam int JOURNAL_DEPTH_DEF = 1024;
  localparam int MEMORY_WORDS_DEF  = 32768;

  localparam int ADDR_W = 15;
  localparam int WORD_W = 16;
  localparam int OP_W   = 3;

  localparam logic [OP_W-1:0] OP_BEGIN   = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE   = 3'd1;
  localparam logic [OP_W-1:0] OP_RESTORE = 3'd2;
  localparam logic [OP_W-1:0] OP_READ    = 3'd3;
  localparam logic [OP_W-1:0] OP_LOAD    = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] address;
    logic [WORD_W-1:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_word;
    logic              restore_ok;
    logic              overflowed;
  } out_item_t;

endpackage

// ===== rtl/mwuj_ram.sv =====
// generic simple dual-port ram with registered read
module mwuj_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/memory_write_undo_journal.sv =====
// word memory with an undo journal: top level, sequencer and output register
// result: begin, write, read and load are executed in S_EXEC after the accepting edge, result registered
// restore: result held back while S_UNWIND writes the N journal entries back, one per cycle
// beats: in_ready is high only in S_IDLE, so a new beat waits until the last one is executed,
//   as the single word memory port pair is read in the accept cycle and written in S_EXEC
// reset: synchronous, active low; a clearing pass then zeroes MEMORY_WORDS words, in_ready low
module memory_write_undo_journal #(
  parameter int JOURNAL_DEPTH = mwuj_pkg::JOURNAL_DEPTH_DEF,
  parameter int MEMORY_WORDS  = mwuj_pkg::MEMORY_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mwuj_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mwuj_pkg::out_item_t out_data
);

  // word memory index width, and a common width to extend 15-bit addresses into
  localparam int MW_AW = (MEMORY_WORDS > 1) ? $clog2(MEMORY_WORDS) : 1;
  localparam int EXT_W = (MW_AW > mwuj_pkg::ADDR_W) ? MW_AW : mwuj_pkg::ADDR_W;
  // journal index and count widths (count must hold the depth itself)
  localparam int JA_W  = (JOURNAL_DEPTH > 1) ? $clog2(JOURNAL_DEPTH) : 1;
  localparam int CNT_W = $clog2(JOURNAL_DEPTH + 1);
  localparam int JW_W  = mwuj_pkg::ADDR_W + mwuj_pkg::WORD_W;

  // sequencer states
  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_EXEC   = 2'd2;
  localparam logic [1:0] S_UNWIND = 2'd3;

  logic [1:0]                 state_r, state_nxt;
  logic [MW_AW-1:0]           clr_idx_r, clr_idx_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic                       ovf_r, ovf_nxt;
  mwuj_pkg::in_item_t         item_r, item_nxt;
  logic                       out_valid_r, out_valid_nxt;
  mwuj_pkg::out_item_t        out_data_r, out_data_nxt;

  // word memory ports
  logic                       mem_we;
  logic [MW_AW-1:0]           mem_waddr;
  logic [mwuj_pkg::WORD_W-1:0] mem_wdata;
  logic [MW_AW-1:0]           mem_raddr;
  logic [mwuj_pkg::WORD_W-1:0] mem_rdata;

  // journal ports: {address, old word}
  logic                       jr_we;
  logic [JA_W-1:0]            jr_waddr;
  logic [JW_W-1:0]            jr_wdata;
  logic [JA_W-1:0]            jr_raddr;
  logic [JW_W-1:0]            jr_rdata;

  logic [EXT_W-1:0]           in_addr_ext, item_addr_ext, jr_addr_ext;
  logic                       addr_ok;
  logic                       full;
  logic [CNT_W-1:0]           count_dec;
  logic                       accept;

  // address extension into the memory index space
  assign in_addr_ext   = EXT_W'(in_data.address);
  assign item_addr_ext = EXT_W'(item_r.address);
  assign jr_addr_ext   = EXT_W'(jr_rdata[JW_W-1:mwuj_pkg::WORD_W]);

  // only meaningful for memories smaller than the 15-bit address space
  assign addr_ok   = ({2'b00, item_r.address} < 17'(MEMORY_WORDS));
  assign full      = (count_r == CNT_W'(JOURNAL_DEPTH));
  assign count_dec = count_r - CNT_W'(1);

  // take a beat only when the output register is free by the next edge
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;

  // old word is fetched in the accept cycle, ready in S_EXEC
  assign mem_raddr = in_addr_ext[MW_AW-1:0];
  // journal pops read the entry below the current count
  assign jr_raddr  = count_dec[JA_W-1:0];
  assign jr_waddr  = count_r[JA_W-1:0];
  assign jr_wdata  = {item_r.address, mem_rdata};

  mwuj_ram #(
    .WIDTH (mwuj_pkg::WORD_W),
    .DEPTH (MEMORY_WORDS),
    .AW    (MW_AW)
  ) u_word_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mwuj_ram #(
    .WIDTH (JW_W),
    .DEPTH (JOURNAL_DEPTH),
    .AW    (JA_W)
  ) u_journal (
    .clk   (clk),
    .we    (jr_we),
    .waddr (jr_waddr),
    .wdata (jr_wdata),
    .raddr (jr_raddr),
    .rdata (jr_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    item_nxt      = item_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = item_addr_ext[MW_AW-1:0];
    mem_wdata     = item_r.data_word;
    jr_we         = 1'b0;

    // result leaves when taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        // zero one word per cycle after reset
        mem_we      = 1'b1;
        mem_waddr   = clr_idx_r;
        mem_wdata   = '0;
        clr_idx_nxt = clr_idx_r + MW_AW'(1);
        if (clr_idx_r == MW_AW'(MEMORY_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          item_nxt  = in_data;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // default result: no read data, no restore flag, current overflow
        out_data_nxt.read_word  = '0;
        out_data_nxt.restore_ok = 1'b0;
        out_data_nxt.overflowed = ovf_r;
        out_valid_nxt           = 1'b1;
        state_nxt               = S_IDLE;
        unique case (item_r.operation)
          mwuj_pkg::OP_BEGIN: begin
            count_nxt               = '0;
            ovf_nxt                 = 1'b0;
            out_data_nxt.overflowed = 1'b0;
          end
          mwuj_pkg::OP_WRITE: begin
            if (addr_ok) begin
              if (full) begin
                // journal full: drop the write, flag it
                ovf_nxt                 = 1'b1;
                out_data_nxt.overflowed = 1'b1;
              end else begin
                // push address and old word, and store the new word in the same cycle
                jr_we     = 1'b1;
                mem_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
          end
          mwuj_pkg::OP_RESTORE: begin
            out_data_nxt.restore_ok = !ovf_r;
            if (count_r != '0) begin
              // first pop issued here, result held back until the journal is empty
              count_nxt     = count_dec;
              out_valid_nxt = 1'b0;
              state_nxt     = S_UNWIND;
            end
          end
          mwuj_pkg::OP_READ: begin
            if (addr_ok) begin
              out_data_nxt.read_word = mem_rdata;
            end
          end
          mwuj_pkg::OP_LOAD: begin
            mem_we = addr_ok;
          end
          default: begin
            // unused codes change nothing
          end
        endcase
      end
      S_UNWIND: begin
        // entry read last cycle goes back into the word memory
        mem_we    = 1'b1;
        mem_waddr = jr_addr_ext[MW_AW-1:0];
        mem_wdata = jr_rdata[mwuj_pkg::WORD_W-1:0];
        if (count_r != '0) begin
          count_nxt = count_dec;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // no beat is taken during the clearing pass
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready)
    else $error("beat accepted during clearing pass");

  // journal count never passes its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(JOURNAL_DEPTH))
    else $error("journal count beyond depth");

  // an accepted beat is executed in the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC))
    else $error("accepted beat not executed");

  // output register is empty while an item is in progress
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EXEC) || (state_r == S_UNWIND)) |-> !out_valid_r)
    else $error("result pending while item in progress");

endmodule
